>>> hw/rtl/sha_pkg.sv
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int LengthPos  = 56;
	localparam logic [7:0] PadMark = 8'h80;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_BOTH = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} cmd_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

>>> hw/rtl/sha_front.sv
module sha_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_data,
	input  logic           in_present,
	input  logic           in_last,
	output logic           q_valid,
	input  logic           q_ready,
	output sha_pkg::cmd_t  q_cmd
);
	sha_pkg::cmd_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;
	sha_pkg::cmd_t c;

	assign in_ready = (cnt_q != 3'd4);
	assign push = in_valid && in_ready && (in_present || in_last);
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 3'd0);
	assign q_cmd = mem_q[rp_q];

	always_comb begin
		c.data = in_data;
		if (in_present && in_last) c.kind = sha_pkg::KIND_BOTH;
		else if (in_last) c.kind = sha_pkg::KIND_END;
		else c.kind = sha_pkg::KIND_BYTE;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

>>> hw/rtl/sha_back.sv
module sha_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  sha_pkg::cmd_t  q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_word,
	output logic [2:0]     out_index,
	output logic           out_last
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_LOAD = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q [8];
	logic [31:0] s_q [8];
	logic [31:0] w_q [16];
	logic [31:0] blk_q [16];
	logic [5:0]  cnt_q;
	logic [63:0] bits_q;
	logic        fin_q, blk_rd_q;
	logic        final_q;
	logic [5:0]  rnd_q;
	logic [4:0]  ld_q;
	logic [31:0] rd_word_q;
	logic [2:0]  oi_q;

	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_data;
	logic [31:0] wnew, t1, t2, wcur;

	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_word = h_q[oi_q];
	assign out_index = oi_q;
	assign out_last = (oi_q == 3'd7);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q;
		wr_data = q_cmd.data;
		if (state_q == ST_IDLE && q_valid) begin
			wr_en = 1'b1;
			if (q_cmd.kind == sha_pkg::KIND_END) wr_data = sha_pkg::PadMark;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			if (fin_q) wr_data = sha_pkg::PadMark;
			else if (cnt_q >= 6'(sha_pkg::LengthPos) && !blk_rd_q)
				wr_data = bits_q[{~cnt_q[2:0], 3'b111} -: 8];
			else wr_data = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) blk_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		rd_word_q <= blk_q[ld_q[3:0]];
	end

	assign wcur = w_q[0];
	always_comb begin
		wnew = w_q[0] + (sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9] + (sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10));
		t1 = s_q[7] + (sha_pkg::rotr(s_q[4], 6) ^ sha_pkg::rotr(s_q[4], 11)
			^ sha_pkg::rotr(s_q[4], 25)) + ((s_q[4] & s_q[5]) ^ (~s_q[4] & s_q[6]))
			+ sha_pkg::RoundK[rnd_q] + wcur;
		t2 = (sha_pkg::rotr(s_q[0], 2) ^ sha_pkg::rotr(s_q[0], 13) ^ sha_pkg::rotr(s_q[0], 22))
			+ ((s_q[0] & s_q[1]) ^ (s_q[0] & s_q[2]) ^ (s_q[1] & s_q[2]));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && ld_q != 5'd0) w_q[4'(ld_q - 5'd1)] <= rd_word_q;
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnew;
		end
		if (state_q == ST_LOAD) for (int i = 0; i < 8; i++) s_q[i] <= h_q[i];
		if (state_q == ST_COMP) begin
			s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4]; s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0]; s_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
			cnt_q <= '0;
			bits_q <= '0;
			fin_q <= 1'b0;
			blk_rd_q <= 1'b0;
			rnd_q <= '0;
			ld_q <= '0;
			oi_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q <= cnt_q + 6'd1;
						if (q_cmd.kind == sha_pkg::KIND_END) begin
							fin_q <= 1'b0;
							blk_rd_q <= (cnt_q >= 6'(sha_pkg::LengthPos));
							if (cnt_q == 6'd63) begin
								ld_q <= '0; state_q <= ST_LOAD;
							end else state_q <= ST_PAD;
						end else begin
							bits_q <= bits_q + 64'd8;
							fin_q <= (q_cmd.kind == sha_pkg::KIND_BOTH);
							blk_rd_q <= (q_cmd.kind == sha_pkg::KIND_BOTH)
								&& (cnt_q >= 6'(sha_pkg::LengthPos - 1)) && (cnt_q != 6'd63);
							if (cnt_q == 6'd63) begin
								ld_q <= '0; state_q <= ST_LOAD;
							end else if (q_cmd.kind == sha_pkg::KIND_BOTH) state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fin_q <= 1'b0;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						ld_q <= '0; state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 5'd1;
					if (ld_q == 5'd16) begin
						rnd_q <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + s_q[i];
					cnt_q <= '0;
					if (fin_q || blk_rd_q) begin
						blk_rd_q <= 1'b0;
						state_q <= ST_PAD;
					end else if (final_q) begin
						oi_q <= '0; state_q <= ST_OUT;
					end else state_q <= ST_IDLE;
				end
				ST_OUT: begin
					if (out_ready) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
							bits_q <= '0;
							cnt_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q <= 1'b0;
		end else if (state_q == ST_IDLE && q_valid && q_cmd.kind != sha_pkg::KIND_BYTE) begin
			final_q <= 1'b1;
		end else if (state_q == ST_OUT && out_ready && oi_q == 3'd7) begin
			final_q <= 1'b0;
		end
	end
endmodule

>>> hw/rtl/sha256_message_hash.sv
// SHA-256 over a byte stream. A slave beat carries at most one message byte, flagged by
// s_tuser, and s_tlast ends the message; a beat with neither is dropped. Bytes go into the
// block buffer at one per cycle while the core is idle; each full 64-byte block then has its
// message words loaded, runs 64 rounds and is added into the hash, while the four-entry front
// queue keeps taking beats until it holds four. The final beat pads the block at one byte per cycle,
// so one or two more blocks are compressed, then the eight digest words leave on the master
// side, H0 first, with m_tlast on H7, and the next message starts from the initial values.
module sha256_message_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tuser,  // byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast   // last_word
);
	logic          q_valid, q_ready;
	sha_pkg::cmd_t q_cmd;
	logic [31:0]   w;
	logic [2:0]    idx;

	sha_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.in_present(s_tuser), .in_last(s_tlast), .q_valid, .q_ready, .q_cmd
	);
	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .out_valid(m_tvalid),
		.out_ready(m_tready), .out_word(w), .out_index(idx), .out_last(m_tlast)
	);
	assign m_tdata = {5'd0, idx, w};
endmodule

>>> hw/rtl/sha_checker.sv
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("last mismatch");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
		&& m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1) else $error("index order");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0) else $error("fill bits");
endmodule

bind sha256_message_hash sha_checker u_chk (.*);
